/* design/sha256_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and sigma functions for the SHA-256 hash core.
// No dependencies; imported by every module of the core.
package sha256_pkg;

    // Control strobes from the sequencer to the schedule and round units
    typedef struct packed {
        logic byte_en;   // shift one message byte into the window
        logic load;      // load working variables from the chain value
        logic round_en;  // run one compression round
    } sha_ctrl_t;

    // Eight 32-bit words, word 0 in the lowest bits
    typedef logic [7:0][31:0] hash_t;

    localparam hash_t HASH_IV = '{
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* design/sha256_hash_core.sv */
`timescale 1ns / 1ps
// SHA-256 hash core top level: sequencer, chain value, padding and output.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
// Usage
//   Slave channel: one transaction per item. tdata holds the message byte,
//   tuser[0] says whether the byte is present, tlast ends the message.
//   Master channel: eight transactions per message, the digest words most
//   significant first; tuser carries the word index, tlast marks word 7.
// Operation
//   Byte transactions are taken back to back while idle. The 64th byte of a
//   block starts the compression: the rounds of the shared round unit, then
//   the chain update, during both of which tready is low. After tlast the
//   core writes padding one byte per cycle up to the block end (a second
//   block when fewer than nine bytes remain), compresses, then loads the
//   digest into the output buffer. Words leave at one per cycle while
//   m_axis_tready is high.
// Reset and stalls
//   aresetn clears the sequencer, the length count and the output buffer's
//   busy flag and word index, and restores the initial hash values. A
//   stalled receiver holds the digest; the next message can be taken
//   meanwhile, but its digest waits until the previous one has drained.
module sha256_hash_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad_done_reg, pad_done_next;
    hash_t       chain_reg, chain_next;
    hash_t       out_buf_reg, out_buf_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_busy_reg, out_busy_next;

    sha_ctrl_t   ctrl;
    logic [7:0]  absorb_byte;
    logic [7:0]  len_byte;
    logic [31:0] w_cur;
    hash_t       vars;
    logic        out_fire;

    sha256_sched u_sched (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .byte_in (absorb_byte),
        .w_cur   (w_cur)
    );

    sha256_round u_round (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .init_hash (chain_reg),
        .k_in      (ROUND_K[rnd_reg]),
        .w_in      (w_cur),
        .vars      (vars)
    );

    // Length field byte, most significant first at offset 56
    assign len_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        bits_next       = bits_reg;
        rnd_next        = rnd_reg;
        phase_next      = phase_reg;
        pad_active_next = pad_active_reg;
        pad_done_next   = pad_done_reg;
        chain_next      = chain_reg;
        ctrl            = '0;
        absorb_byte     = s_axis_tdata;
        out_buf_next    = out_buf_reg;
        out_idx_next    = out_idx_reg;
        out_busy_next   = out_busy_reg;

        // Output buffer drains one word per transaction
        if (out_fire) begin
            out_buf_next = {32'd0, out_buf_reg[7:1]};
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7) begin
                out_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tlast) begin
                        pad_active_next = 1'b1;
                        phase_next      = PH_MARK;
                        state_next      = ST_PAD;
                    end
                    if (s_axis_tuser) begin
                        ctrl.byte_en = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        bits_next    = bits_reg + 64'd8;
                        if (fill_reg == 6'd63) begin
                            ctrl.load  = 1'b1;
                            rnd_next   = '0;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD: begin
                ctrl.byte_en = 1'b1;
                fill_next    = fill_reg + 6'd1;
                unique case (phase_reg)
                    PH_MARK: begin
                        absorb_byte = 8'h80;
                        phase_next  = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (fill_reg == 6'd56) begin
                            absorb_byte = len_byte;
                            phase_next  = PH_LEN;
                        end else begin
                            absorb_byte = 8'h00;
                        end
                    end
                    PH_LEN: begin
                        absorb_byte = len_byte;
                        if (fill_reg == 6'd63) begin
                            pad_done_next = 1'b1;
                        end
                    end
                    default: begin
                        absorb_byte = 8'h00;
                    end
                endcase
                if (fill_reg == 6'd63) begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctrl.round_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                priority if (pad_done_reg) begin
                    state_next = ST_EMIT;
                end else if (pad_active_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Wait for the previous digest to drain
                if (!out_busy_reg) begin
                    out_buf_next    = chain_reg;
                    out_idx_next    = '0;
                    out_busy_next   = 1'b1;
                    chain_next      = HASH_IV;
                    bits_next       = '0;
                    pad_active_next = 1'b0;
                    pad_done_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            bits_reg       <= '0;
            rnd_reg        <= '0;
            phase_reg      <= PH_MARK;
            pad_active_reg <= 1'b0;
            pad_done_reg   <= 1'b0;
            chain_reg      <= HASH_IV;
            out_idx_reg    <= '0;
            out_busy_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bits_reg       <= bits_next;
            rnd_reg        <= rnd_next;
            phase_reg      <= phase_next;
            pad_active_reg <= pad_active_next;
            pad_done_reg   <= pad_done_next;
            chain_reg      <= chain_next;
            out_idx_reg    <= out_idx_next;
            out_busy_reg   <= out_busy_next;
        end
    end

    // Digest buffer, payload only
    always_ff @(posedge aclk) begin
        out_buf_reg <= out_buf_next;
    end

    assign m_axis_tvalid = out_busy_reg;
    assign m_axis_tdata  = out_buf_reg[0];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

endmodule

/* design/sha256_sched.sv */
`timescale 1ns / 1ps
// Message window: collects bytes of a block, then expands the schedule.
// Depends on sha256_pkg.
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  sha_ctrl_t   ctrl,
    input  logic [7:0]  byte_in,
    output logic [31:0] w_cur
);

    // 16-word window, oldest word W[r] in the top 32 bits
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  new_w;

    // W[r+16] from W[r], W[r+1], W[r+9], W[r+14]
    assign new_w = win_reg[511:480] + small_sigma0(win_reg[479:448])
                 + win_reg[223:192] + small_sigma1(win_reg[63:32]);

    assign w_cur = win_reg[511:480];

    always_comb begin
        win_next = win_reg;
        if (ctrl.byte_en) begin
            win_next = {win_reg[503:0], byte_in};
        end else if (ctrl.round_en) begin
            win_next = {win_reg[479:0], new_w};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

/* design/sha256_round.sv */
`timescale 1ns / 1ps
// Shared compression round unit: working variables a..h and one round.
// Depends on sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  sha_ctrl_t   ctrl,
    input  hash_t       init_hash,
    input  logic [31:0] k_in,
    input  logic [31:0] w_in,
    output hash_t       vars
);

    hash_t       vars_reg;
    hash_t       vars_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // One round, word 0 is a, word 7 is h
    assign ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
    assign t1  = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + k_in + w_in;
    assign t2  = big_sigma0(vars_reg[0]) + maj;

    always_comb begin
        vars_next = vars_reg;
        if (ctrl.load) begin
            vars_next = init_hash;
        end else if (ctrl.round_en) begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;

endmodule

/* design/sha256_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the SHA-256 hash core, bound to the top level.
// Depends only on the ports of sha256_hash_core.
module sha256_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Nothing valid right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // tlast only on word 7
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast does not match word index");

    // Words of a digest follow each other without gaps
    a_word_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
        else $error("digest words out of sequence");

    // End of message starts padding, so input stalls
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during padding");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sha256_hash_core sha256_checker u_sha256_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// Digest checker for sha256_hash_core: predicts SHA-256 digests from the
// accepted byte transactions and compares every digest word leaving the core.
// Self-contained; needs no package.
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // is_last
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_axis_tuser,   // [2:0] word_index
    input  logic        m_axis_tlast,   // last_word
    output int          mismatches,
    output int          outstanding
);

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam int         LEN_OFFSET = 56;
    localparam int         PRINT_CAP  = 40;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // Predicted hashing state
    logic [31:0]  hash_chain [8];
    logic [7:0]   blk_buf [64];
    int           blk_fill;
    logic [63:0]  msg_bits;
    digest_beat_t digest_q [$];
    int           fail_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic void clear_state();
        for (int i = 0; i < 8; i++)
            hash_chain[i] = INIT_HASH[i];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    // 64 rounds over the buffered block, then fold into the chain value
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 0; i < 8; i++)
            v[i] = hash_chain[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                s0 = rotr(w[(r-15)%16], 7) ^ rotr(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
                s1 = rotr(w[(r-2)%16], 17) ^ rotr(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
                wr = w[r%16] + s0 + w[(r-7)%16] + s1;
                w[r%16] = wr;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wr;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_chain[i] = hash_chain[i] + v[i];
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        blk_buf[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    // One accepted input transaction; a message end queues the eight digest words
    function automatic void take_item(input logic [7:0] b, input logic has_b,
                                      input logic ends);
        logic [63:0]  len;
        digest_beat_t beat;
        if (has_b) begin
            push_byte(b);
            msg_bits = msg_bits + 64'd8;
        end
        if (ends) begin
            len = msg_bits;
            push_byte(PAD_MARKER);
            while (blk_fill != LEN_OFFSET)
                push_byte(8'h00);
            for (int i = 0; i < 8; i++)
                push_byte(len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                beat.word  = hash_chain[i];
                beat.index = 3'(i);
                beat.last  = (i == 7);
                digest_q = {digest_q, beat};
            end
            clear_state();
        end
    endfunction

    task automatic report(input string msg);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: digest check: %s", $time, msg);
        fail_count++;
    endtask

    initial begin
        fail_count  = 0;
        mismatches  = 0;
        outstanding = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            clear_state();
            digest_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    report($sformatf("unexpected digest word %h index %0d",
                                     m_axis_tdata, m_axis_tuser));
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_axis_tdata !== exp_beat.word)
                        report($sformatf("word %0d: got %h, predicted %h",
                                         exp_beat.index, m_axis_tdata, exp_beat.word));
                    if (m_axis_tuser !== exp_beat.index)
                        report($sformatf("word index: got %0d, predicted %0d",
                                         m_axis_tuser, exp_beat.index));
                    if (m_axis_tlast !== exp_beat.last)
                        report($sformatf("word %0d: tlast got %b, predicted %b",
                                         exp_beat.index, m_axis_tlast, exp_beat.last));
                end
            end
        end
        mismatches  <= fail_count;
        outstanding <= digest_q.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the sha256_hash_core testbench: clock, reset, byte stimulus, back-pressure
// and verdict. Depends on sha256_hash_core and sha256_digest_checker.
module tb_top;

    localparam int RAND_ITEMS  = 210;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 300;
    localparam int BOUNDARY_LENS [6] = '{55, 56, 57, 63, 64, 65};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] has_byte
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;   // last_word

    int mismatches;
    int outstanding;
    bit tx_steady = 1'b0;   // sender inserts no random idle gaps while set
    int items_sent = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sha256_hash_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_digest_checker digest_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Offer one byte transaction, with an optional random idle gap ahead of it
    task automatic send_item(input logic [7:0] b, input logic has_b, input logic ends);
        while (!tx_steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has_b;
        s_axis_tlast  <= ends;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_digests_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Mostly short messages; some straddle the length field boundary
    function automatic int pick_msg_len();
        if ($urandom_range(0, 9) < 3)
            return BOUNDARY_LENS[$urandom_range(0, 5)];
        return $urandom_range(0, 16);
    endfunction

    // One random message; the end may ride on the last byte or on a bare item
    task automatic send_message(input int len);
        bit bare_end;
        bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1));
            items_sent++;
        end
        if (bare_end) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    // Receiver: random stalls, one quiet window and one long hold-off
    initial begin
        int cyc;
        int beats;
        int hold_left;
        bit held;
        cyc = 0;
        beats = 0;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_axis_tvalid && m_axis_tready)
                beats++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held && beats >= 40) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (cyc >= 1000 && cyc < 2000) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        bit paused;
        paused = 1'b0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message
        send_item(8'hA5, 1'b0, 1'b1);
        // ignored item, then a single zero byte ending the message
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // single all-ones byte
        send_item(8'hFF, 1'b1, 1'b1);
        // three bytes, end carried by an item without a byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        wait_digests_drained();

        // random messages
        while (items_sent < RAND_ITEMS) begin
            tx_steady = (items_sent >= 90 && items_sent < 150);
            if (!paused && items_sent >= 120) begin
                paused = 1'b1;
                wait_digests_drained();
            end
            send_message(pick_msg_len());
        end
        tx_steady = 1'b0;

        wait_digests_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
design/sha256_pkg.sv
design/sha256_sched.sv
design/sha256_round.sv
design/sha256_hash_core.sv
design/sha256_checker.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_top.sv
